@@ rtl/ebrd_pkg.sv @@
`default_nettype none
package ebrd_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int COUNT_BITS  = 20;
  localparam int NUM_BITS    = 20;
  localparam int RATE_BITS   = 20;
  localparam int SLOT_BITS   = 3;
  localparam int RATE_SLOTS  = 5;

  localparam logic [NUM_BITS-1:0] NUM_RESET = NUM_BITS'(60000);

  localparam int CMD_DEPTH     = 2;
  localparam int CMD_PTR_BITS  = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_BITS  = $clog2(CMD_DEPTH + 1);

  typedef struct packed {
    logic                  beat;
    logic [COUNT_BITS-1:0] count;
    logic [SLOT_BITS-1:0]  slot;
    logic                  armed;
  } cmd_t;

  typedef struct packed {
    logic                 beat;
    logic [RATE_BITS-1:0] rate;
    logic [SLOT_BITS-1:0] slot;
    logic                 armed;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/ecg_beat_rate_detector.sv @@
// ECG beat and rate detector.
// Input channel: drive sample_i and raise push; a sample is taken at a clock
// edge where push is high and full is low. Result channel: while empty is
// low, beat_o, rate_o, slot_o and armed_o show the oldest result; raise pop
// to take it. Configuration: cfg_data_i carries rate_numerator and is written
// when cfg_valid_i and cfg_ready_o are both high; write only while idle.
// A sample that is not a beat shows its result after it passes through the
// command queue and the result register; a beat runs a restoring divider
// one quotient bit per cycle, and its result shows once the division ends.
// Throughput: one sample per cycle between beats while the receiver pops
// results; a beat holds the back end for the 20-step divider, while a
// two-entry command queue keeps the front end taking samples until it fills.
// Reset clears the peak, interval counter, hysteresis flag, ring slot and all
// queues, and loads rate_numerator with 60000.
// When the receiver stalls, the result holds, the command queue fills and
// full rises; no sample or result is lost.
`default_nettype none
module ecg_beat_rate_detector
  import ebrd_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  output logic                        empty,
  input  wire logic                   pop,
  output logic                        beat_o,
  output logic [RATE_BITS-1:0]        rate_o,
  output logic [SLOT_BITS-1:0]        slot_o,
  output logic                        armed_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [NUM_BITS-1:0]    cfg_data_i
);

  logic [NUM_BITS-1:0] numerator_q;
  cmd_t                front_cmd, back_cmd;
  logic                accept, cmd_empty, cmd_pop, res_valid;
  result_t             res;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      numerator_q <= NUM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      numerator_q <= cfg_data_i;
    end
  end

  ebrd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sample_i (sample_i),
    .cmd_o    (front_cmd)
  );

  ebrd_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd),
    .empty_o (cmd_empty)
  );

  ebrd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (!cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .numerator_i (numerator_q),
    .pop_i       (pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign empty   = !res_valid;
  assign beat_o  = res.beat;
  assign rate_o  = res.rate;
  assign slot_o  = res.slot;
  assign armed_o = res.armed;

endmodule
`default_nettype wire

@@ rtl/ebrd_front.sv @@
`default_nettype none
module ebrd_front
  import ebrd_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   accept_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  output cmd_t                        cmd_o
);

  localparam int CMP_BITS = SAMPLE_BITS + 4;

  logic                   seen_q, seen_d;
  logic [SAMPLE_BITS-1:0] peak_q, peak_d;
  logic [COUNT_BITS-1:0]  count_q, count_d;
  logic                   armed_q, armed_d;
  logic [SLOT_BITS-1:0]   slot_q, slot_d;

  logic [COUNT_BITS-1:0]  count_inc;
  logic [CMP_BITS-1:0]    s_ext, p_ext, s_one;
  logic                   above_hi, below_lo, beat;

  always_comb begin
    peak_d    = (!seen_q || (sample_i > peak_q)) ? sample_i : peak_q;
    seen_d    = 1'b1;
    s_ext     = CMP_BITS'(sample_i);
    p_ext     = CMP_BITS'(peak_d);
    s_one     = s_ext + CMP_BITS'(1);
    above_hi  = (p_ext << 2) < ((s_ext << 2) + s_ext);
    below_lo  = ((s_one << 3) + (s_one << 1)) <= ((p_ext << 3) - p_ext);
    count_inc = (count_q != '1) ? count_q + COUNT_BITS'(1) : count_q;
    beat      = above_hi && !armed_q;
    if (beat) begin
      armed_d = 1'b1;
    end else if (below_lo && armed_q) begin
      armed_d = 1'b0;
    end else begin
      armed_d = armed_q;
    end
    count_d = beat ? '0 : count_inc;
    if (!beat) begin
      slot_d = slot_q;
    end else if (slot_q == SLOT_BITS'(RATE_SLOTS - 1)) begin
      slot_d = '0;
    end else begin
      slot_d = slot_q + SLOT_BITS'(1);
    end
    cmd_o.beat  = beat;
    cmd_o.count = count_inc;
    cmd_o.slot  = slot_q;
    cmd_o.armed = armed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= 1'b0;
      peak_q  <= '0;
      count_q <= '0;
      armed_q <= 1'b0;
      slot_q  <= '0;
    end else if (accept_i) begin
      seen_q  <= seen_d;
      peak_q  <= peak_d;
      count_q <= count_d;
      armed_q <= armed_d;
      slot_q  <= slot_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/ebrd_cmd_fifo.sv @@
`default_nettype none
module ebrd_cmd_fifo
  import ebrd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      data_o,
  output logic      empty_o
);

  cmd_t                    mem_q [CMD_DEPTH];
  logic [CMD_PTR_BITS-1:0] wptr_q, rptr_q;
  logic [CMD_CNT_BITS-1:0] cnt_q;
  logic                    do_push, do_pop;

  assign full_o  = (cnt_q == CMD_CNT_BITS'(CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + CMD_PTR_BITS'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + CMD_PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CMD_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CMD_CNT_BITS'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/ebrd_back.sv @@
`default_nettype none
module ebrd_back
  import ebrd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  cmd_t                     cmd_i,
  input  wire logic                cmd_valid_i,
  output logic                     cmd_pop_o,
  input  wire logic [NUM_BITS-1:0] numerator_i,
  input  wire logic                pop_i,
  output logic                     res_valid_o,
  output result_t                  res_o
);

  localparam int TRIAL_BITS = NUM_BITS + 1;
  localparam int STEP_BITS  = $clog2(NUM_BITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_e;

  state_e                 state_q;
  logic [NUM_BITS-1:0]    rem_q, rem_d;
  logic [NUM_BITS-1:0]    quo_q, quo_d;
  logic [COUNT_BITS-1:0]  div_q;
  logic [STEP_BITS-1:0]   step_q;
  logic [SLOT_BITS-1:0]   slot_q;
  logic                   armed_q;
  logic                   out_valid_q;
  result_t                out_q;
  logic                   out_free;
  logic                   load_out;
  logic [TRIAL_BITS-1:0]  trial, div_ext;
  logic                   ge;

  assign out_free    = !out_valid_q || pop_i;
  assign cmd_pop_o   = (state_q == S_IDLE) && cmd_valid_i && out_free;
  assign load_out    = ((state_q == S_IDLE) && cmd_pop_o && !cmd_i.beat) ||
                       ((state_q == S_EMIT) && out_free);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    trial   = {rem_q, quo_q[NUM_BITS-1]};
    div_ext = TRIAL_BITS'(div_q);
    ge      = trial >= div_ext;
    rem_d   = ge ? NUM_BITS'(trial - div_ext) : NUM_BITS'(trial);
    quo_d   = {quo_q[NUM_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rem_q       <= '0;
      quo_q       <= '0;
      div_q       <= '0;
      step_q      <= '0;
      slot_q      <= '0;
      armed_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_pop_o) begin
            if (cmd_i.beat) begin
              rem_q   <= '0;
              quo_q   <= numerator_i;
              div_q   <= cmd_i.count;
              step_q  <= '0;
              slot_q  <= cmd_i.slot;
              armed_q <= cmd_i.armed;
              state_q <= S_DIV;
            end else begin
              out_q <= '{beat: 1'b0, rate: '0, slot: '0, armed: cmd_i.armed};
            end
          end
        end
        S_DIV: begin
          rem_q  <= rem_d;
          quo_q  <= quo_d;
          step_q <= step_q + STEP_BITS'(1);
          if (step_q == STEP_BITS'(NUM_BITS - 1)) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_q   <= '{beat: 1'b1, rate: RATE_BITS'(quo_q), slot: slot_q,
                         armed: armed_q};
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/ebrd_checker.sv @@
`default_nettype none
module ebrd_checker
  import ebrd_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 pop,
  input wire logic                 empty,
  input wire logic                 beat_o,
  input wire logic [RATE_BITS-1:0] rate_o,
  input wire logic [SLOT_BITS-1:0] slot_o,
  input wire logic                 armed_o
);

  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !beat_o) |-> (rate_o == '0 && slot_o == '0))
    else $error("non-beat result carries rate or slot");

  a_beat_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && beat_o) |-> armed_o)
    else $error("beat result without armed flag");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (slot_o < SLOT_BITS'(RATE_SLOTS)))
    else $error("ring slot out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(rate_o) && $stable(beat_o)))
    else $error("stalled result changed");

endmodule

bind ecg_beat_rate_detector ebrd_checker u_ebrd_checker (.*);
`default_nettype wire
